@@ design/kth_pkg.sv @@
// ----------------------------------------------------------------------------
// kth_pkg: shared constants for the key table with hold flag
// Field widths, operation codes and status codes.
// ----------------------------------------------------------------------------
package kth_pkg;

    localparam int KEY_W      = 16;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int CFG_W      = 5;
    localparam int OUT_CNT_W  = 5;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ACQUIRE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_HELD     = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_HELD = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_DUP      = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_MISSING  = 3'd5;

endpackage

@@ design/key_table_with_hold_flag.sv @@
// ----------------------------------------------------------------------------
// key_table_with_hold_flag: bounded key table with per-key hold flag
// Insert, remove, acquire and release on unique 16-bit keys, found by a
// linear scan with one comparator over a single-port-write table memory.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid / s_ready  s_kind, s_key
//   m_        out        m_valid / m_ready  m_status, m_entry_count
//   cfg_      in         cfg_we             cfg_wdata (capacity limit)
//
// A request scans the stored keys one per cycle through the memory read port;
// a remove then moves the last entry into the freed slot, and an insert on a
// full table skips the scan. The output register holds one result, so the next
// request scans while a result waits; it stalls only at its finish.
// Reset: synchronous, active low; count clears, table contents undefined.
// ----------------------------------------------------------------------------
module key_table_with_hold_flag #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [kth_pkg::KIND_W-1:0]    s_kind,
    input  logic [kth_pkg::KEY_W-1:0]     s_key,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [kth_pkg::STATUS_W-1:0]  m_status,
    output logic [kth_pkg::OUT_CNT_W-1:0] m_entry_count,

    input  logic                          cfg_we,
    input  logic [kth_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LIM_W  = (CNT_W > kth_pkg::CFG_W) ? CNT_W : kth_pkg::CFG_W;
    localparam int WORD_W = kth_pkg::KEY_W + 1;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_MOVE_RD = 3'd2;
    localparam logic [2:0] ST_MOVE_WR = 3'd3;
    localparam logic [2:0] ST_FINISH  = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [kth_pkg::KIND_W-1:0]    kind_reg, kind_next;
    logic [kth_pkg::KEY_W-1:0]     key_reg, key_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [kth_pkg::CFG_W-1:0]     cap_reg;
    logic [CNT_W-1:0]              scan_idx_reg, scan_idx_next;
    logic                          cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]                 cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]                 slot_reg, slot_next;
    logic [kth_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic                          m_valid_reg, m_valid_next;
    logic [kth_pkg::STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [kth_pkg::OUT_CNT_W-1:0] m_count_reg, m_count_next;

    logic [WORD_W-1:0] key_mem [TABLE_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [WORD_W-1:0] wr_data;

    logic [LIM_W-1:0]  limit;
    logic              is_full;
    logic              hit;
    logic [CNT_W-1:0]  last_idx;
    logic              rd_flag;

    always_comb begin
        if (LIM_W'(cap_reg) < LIM_W'(TABLE_DEPTH)) begin
            limit = LIM_W'(cap_reg);
        end else begin
            limit = LIM_W'(TABLE_DEPTH);
        end
    end

    assign is_full  = LIM_W'(count_reg) >= limit;
    assign hit      = cmp_valid_reg && (rd_data_reg[kth_pkg::KEY_W-1:0] == key_reg);
    assign rd_flag  = rd_data_reg[kth_pkg::KEY_W];
    assign last_idx = count_reg - CNT_W'(1);

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_count_reg;

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        slot_next      = slot_reg;
        status_next    = status_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_count_next   = m_count_reg;
        rd_en          = 1'b0;
        rd_addr        = scan_idx_reg[AW-1:0];
        wr_en          = 1'b0;
        wr_addr        = slot_reg;
        wr_data        = {1'b0, key_reg};

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next     = s_kind;
                    key_next      = s_key;
                    scan_idx_next = '0;
                    if (s_kind == kth_pkg::KIND_INSERT && is_full) begin
                        status_next = kth_pkg::STATUS_FULL;
                        state_next  = ST_FINISH;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    slot_next  = cmp_idx_reg;
                    state_next = ST_FINISH;
                    case (kind_reg)
                        kth_pkg::KIND_INSERT: begin
                            status_next = kth_pkg::STATUS_DUP;
                        end
                        kth_pkg::KIND_REMOVE: begin
                            state_next = ST_MOVE_RD;
                        end
                        kth_pkg::KIND_ACQUIRE: begin
                            if (rd_flag) begin
                                status_next = kth_pkg::STATUS_HELD;
                            end else begin
                                wr_en       = 1'b1;
                                wr_addr     = cmp_idx_reg;
                                wr_data     = {1'b1, key_reg};
                                status_next = kth_pkg::STATUS_OK;
                            end
                        end
                        default: begin
                            if (!rd_flag) begin
                                status_next = kth_pkg::STATUS_NOT_HELD;
                            end else begin
                                wr_en       = 1'b1;
                                wr_addr     = cmp_idx_reg;
                                wr_data     = {1'b0, key_reg};
                                status_next = kth_pkg::STATUS_OK;
                            end
                        end
                    endcase
                end else if (scan_idx_reg == count_reg) begin
                    state_next = ST_FINISH;
                    if (kind_reg == kth_pkg::KIND_INSERT) begin
                        wr_en       = 1'b1;
                        wr_addr     = count_reg[AW-1:0];
                        wr_data     = {1'b0, key_reg};
                        count_next  = count_reg + CNT_W'(1);
                        status_next = kth_pkg::STATUS_OK;
                    end else begin
                        status_next = kth_pkg::STATUS_MISSING;
                    end
                end else begin
                    rd_en          = 1'b1;
                    rd_addr        = scan_idx_reg[AW-1:0];
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg[AW-1:0];
                    scan_idx_next  = scan_idx_reg + CNT_W'(1);
                end
            end
            ST_MOVE_RD: begin
                rd_en      = 1'b1;
                rd_addr    = last_idx[AW-1:0];
                state_next = ST_MOVE_WR;
            end
            ST_MOVE_WR: begin
                wr_en       = 1'b1;
                wr_addr     = slot_reg;
                wr_data     = rd_data_reg;
                count_next  = last_idx;
                status_next = kth_pkg::STATUS_OK;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_count_next  = kth_pkg::OUT_CNT_W'(count_reg);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= key_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= kth_pkg::CAP_RESET;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        key_reg      <= key_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        slot_reg     <= slot_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_cmp_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_valid_reg |-> state_reg == ST_SCAN)
        else $error("compare data valid outside scan");

    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> state_reg != ST_IDLE && state_reg != ST_FINISH)
        else $error("table write while idle or finishing");

    a_accept_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> $stable(count_reg))
        else $error("count changed on request transfer");
`endif

endmodule

@@ dv/tb_key_table_with_hold_flag.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_table_with_hold_flag: self-checking testbench for the key table
// Drives insert, remove, acquire and release requests over the s_ channel,
// predicts status and entry count per request in a local table model, and
// checks every m_ transfer in order. Covers capacity limit settings, flag
// moves on remove, back pressure and randomized traffic with random gaps.
// ----------------------------------------------------------------------------
module tb_key_table_with_hold_flag;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 2 * DEPTH + 8;

    typedef struct packed {
        logic [kth_pkg::STATUS_W-1:0]  status;
        logic [kth_pkg::OUT_CNT_W-1:0] entry_count;
    } reply_t;

    logic                           aclk          = 1'b0;
    logic                           aresetn       = 1'b0;
    logic                           s_valid       = 1'b0;
    logic                           s_ready;
    logic [kth_pkg::KIND_W-1:0]     s_kind        = kth_pkg::KIND_INSERT;
    logic [kth_pkg::KEY_W-1:0]      s_key         = '0;
    logic                           m_valid;
    logic                           m_ready       = 1'b0;
    logic [kth_pkg::STATUS_W-1:0]   m_status;
    logic [kth_pkg::OUT_CNT_W-1:0]  m_entry_count;
    logic                           cfg_we        = 1'b0;
    logic [kth_pkg::CFG_W-1:0]      cfg_wdata     = '0;

    // table model
    logic [kth_pkg::KEY_W-1:0]      tbl_keys [DEPTH];
    logic                           tbl_held [DEPTH];
    int unsigned                    tbl_count = 0;
    int unsigned                    tbl_cap   = 32'(kth_pkg::CAP_RESET);

    reply_t                pending_replies [$];
    int                    err_count  = 0;
    int                    cycle_cnt  = 0;
    bit                    no_idle    = 1'b0;
    int                    hold_req   = 0;
    int                    hold_left  = 0;
    int                    stall_left = 0;

    key_table_with_hold_flag #(.TABLE_DEPTH(DEPTH)) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_key         (s_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_count (m_entry_count),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d replies outstanding", $time,
                     pending_replies.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int find_slot(input logic [kth_pkg::KEY_W-1:0] key);
        for (int i = 0; i < tbl_count && i < DEPTH; i++) begin
            if (tbl_keys[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic reply_t table_apply(input logic [kth_pkg::KIND_W-1:0] kind,
                                           input logic [kth_pkg::KEY_W-1:0] key);
        reply_t      rep;
        int          slot;
        int unsigned limit;
        limit = (tbl_cap < DEPTH) ? tbl_cap : DEPTH;
        slot  = find_slot(key);
        if (kind == kth_pkg::KIND_INSERT) begin
            if (tbl_count >= limit) begin
                rep.status = kth_pkg::STATUS_FULL;
            end else if (slot >= 0) begin
                rep.status = kth_pkg::STATUS_DUP;
            end else begin
                tbl_keys[tbl_count] = key;
                tbl_held[tbl_count] = 1'b0;
                tbl_count++;
                rep.status = kth_pkg::STATUS_OK;
            end
        end else if (slot < 0) begin
            rep.status = kth_pkg::STATUS_MISSING;
        end else if (kind == kth_pkg::KIND_REMOVE) begin
            tbl_keys[slot] = tbl_keys[tbl_count-1];
            tbl_held[slot] = tbl_held[tbl_count-1];
            tbl_count--;
            rep.status = kth_pkg::STATUS_OK;
        end else if (kind == kth_pkg::KIND_ACQUIRE) begin
            if (tbl_held[slot]) begin
                rep.status = kth_pkg::STATUS_HELD;
            end else begin
                tbl_held[slot] = 1'b1;
                rep.status = kth_pkg::STATUS_OK;
            end
        end else begin
            if (!tbl_held[slot]) begin
                rep.status = kth_pkg::STATUS_NOT_HELD;
            end else begin
                tbl_held[slot] = 1'b0;
                rep.status = kth_pkg::STATUS_OK;
            end
        end
        rep.entry_count = tbl_count[kth_pkg::OUT_CNT_W-1:0];
        return rep;
    endfunction

    // receiver: random stalls plus long hold-off on request
    always @(posedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    // result checker
    always @(posedge aclk) begin
        reply_t exp_rep;
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual status %0d count %0d",
                         $time, m_status, m_entry_count);
                err_count++;
            end else begin
                exp_rep = pending_replies.pop_front();
                if (m_status !== exp_rep.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, exp_rep.status, m_status);
                    err_count++;
                end
                if (m_entry_count !== exp_rep.entry_count) begin
                    $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                             $time, exp_rep.entry_count, m_entry_count);
                    err_count++;
                end
            end
        end
    end

    // valid stays high from the previous transfer when the gap is zero
    task automatic send_request(input logic [kth_pkg::KIND_W-1:0] kind,
                                input logic [kth_pkg::KEY_W-1:0] key);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_key   <= key;
        do @(posedge aclk); while (!s_ready);
        pending_replies.push_back(table_apply(kind, key));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_replies.size() != 0);
    endtask

    task automatic write_capacity(input logic [kth_pkg::CFG_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        tbl_cap    = 32'(value);
    endtask

    task automatic test_directed();
        send_request(kth_pkg::KIND_RELEASE, 16'h0000);
        send_request(kth_pkg::KIND_ACQUIRE, 16'hFFFF);
        send_request(kth_pkg::KIND_REMOVE,  16'h5A5A);
        send_request(kth_pkg::KIND_INSERT,  16'h0000);
        send_request(kth_pkg::KIND_INSERT,  16'hFFFF);
        send_request(kth_pkg::KIND_INSERT,  16'hFFFF);
        send_request(kth_pkg::KIND_ACQUIRE, 16'hFFFF);
        send_request(kth_pkg::KIND_ACQUIRE, 16'hFFFF);
        send_request(kth_pkg::KIND_RELEASE, 16'h0000);
        send_request(kth_pkg::KIND_RELEASE, 16'hFFFF);
        send_request(kth_pkg::KIND_RELEASE, 16'hFFFF);
        send_request(kth_pkg::KIND_ACQUIRE, 16'hFFFF);
        send_request(kth_pkg::KIND_REMOVE,  16'h0000);
        send_request(kth_pkg::KIND_ACQUIRE, 16'hFFFF);
        send_request(kth_pkg::KIND_RELEASE, 16'hFFFF);
        send_request(kth_pkg::KIND_REMOVE,  16'h0000);
        send_request(kth_pkg::KIND_REMOVE,  16'hFFFF);
        send_request(kth_pkg::KIND_ACQUIRE, 16'hFFFF);
        wait_drained();
    endtask

    task automatic test_capacity_limits();
        write_capacity(5'd0);
        send_request(kth_pkg::KIND_INSERT,  16'h1234);
        send_request(kth_pkg::KIND_ACQUIRE, 16'h1234);
        write_capacity(5'd2);
        send_request(kth_pkg::KIND_INSERT,  16'hA000);
        send_request(kth_pkg::KIND_INSERT,  16'hB000);
        send_request(kth_pkg::KIND_INSERT,  16'hA000);   // full beats duplicate
        send_request(kth_pkg::KIND_INSERT,  16'hC000);
        write_capacity(5'd16);
        send_request(kth_pkg::KIND_INSERT,  16'hC000);
        send_request(kth_pkg::KIND_INSERT,  16'hD000);
        send_request(kth_pkg::KIND_INSERT,  16'hE000);
        write_capacity(5'd2);                            // limit below count
        send_request(kth_pkg::KIND_INSERT,  16'hF000);
        send_request(kth_pkg::KIND_ACQUIRE, 16'hC000);
        send_request(kth_pkg::KIND_REMOVE,  16'hC000);
        send_request(kth_pkg::KIND_REMOVE,  16'hD000);
        send_request(kth_pkg::KIND_REMOVE,  16'hE000);
        send_request(kth_pkg::KIND_INSERT,  16'hF000);
        send_request(kth_pkg::KIND_REMOVE,  16'hB000);
        send_request(kth_pkg::KIND_INSERT,  16'hF000);
        write_capacity(5'd31);                           // limit above depth
        for (int i = 0; i < DEPTH - 2; i++) begin
            send_request(kth_pkg::KIND_INSERT, 16'(16'h2000 + i));
        end
        send_request(kth_pkg::KIND_INSERT,  16'h3000);
        send_request(kth_pkg::KIND_INSERT,  16'hA000);
        send_request(kth_pkg::KIND_ACQUIRE, 16'h2003);
        send_request(kth_pkg::KIND_REMOVE,  16'hA000);
        send_request(kth_pkg::KIND_REMOVE,  16'hF000);
        for (int i = 0; i < DEPTH - 2; i++) begin
            send_request(kth_pkg::KIND_REMOVE, 16'(16'h2000 + i));
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_req = 300;
        no_idle  = 1'b1;
        for (int i = 0; i < 12; i++) begin
            send_request((i % 3 == 2) ? kth_pkg::KIND_ACQUIRE : kth_pkg::KIND_INSERT,
                         16'(16'h4000 + (i / 3) * 16'h0101 + i));
        end
        no_idle = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_traffic(input logic [kth_pkg::CFG_W-1:0] cap,
                                       input int n_items);
        logic [kth_pkg::KEY_W-1:0]  pool [24];
        logic [kth_pkg::KEY_W-1:0]  key;
        logic [kth_pkg::KIND_W-1:0] kind;
        int                         r;
        write_capacity(cap);
        foreach (pool[i]) pool[i] = 16'($urandom());
        pool[0] = 16'h0000;
        pool[1] = 16'hFFFF;
        for (int n = 0; n < n_items; n++) begin
            r = $urandom_range(0, 99);
            if (r < 35)      kind = kth_pkg::KIND_INSERT;
            else if (r < 55) kind = kth_pkg::KIND_REMOVE;
            else if (r < 80) kind = kth_pkg::KIND_ACQUIRE;
            else             kind = kth_pkg::KIND_RELEASE;
            if ($urandom_range(0, 99) < 85) key = pool[$urandom_range(0, 23)];
            else                            key = 16'($urandom());
            send_request(kind, key);
        end
    endtask

    initial begin
        tbl_count = 0;
        tbl_cap   = 32'(kth_pkg::CAP_RESET);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_capacity_limits();
        test_backpressure();
        test_random_traffic(5'd16, 200);
        test_random_traffic(5'd5, 190);
        test_random_traffic(5'd0, 120);
        test_random_traffic(5'd1, 150);
        test_random_traffic(5'd31, 200);
        no_idle = 1'b1;
        test_random_traffic(5'd16, 130);
        no_idle = 1'b0;
        test_backpressure();
        test_random_traffic(5'($urandom_range(0, 31)), 160);
        test_random_traffic(5'($urandom_range(2, 15)), 160);
        test_random_traffic(5'($urandom_range(0, 31)), 150);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
